// ----- rtl/core/klqm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package klqm_pkg;
  localparam int unsigned Entries = 16;
  localparam int unsigned Items = 32;
  localparam int unsigned SlotW = $clog2(Entries + 1);
  localparam int unsigned SlotIdxW = $clog2(Entries);
  localparam int unsigned ItemW = $clog2(Items + 1);
  localparam int unsigned ItemIdxW = $clog2(Items);
  localparam logic [SlotW-1:0] SlotNull = SlotW'(Entries);
  localparam logic [ItemW-1:0] ItemNull = ItemW'(Items);

  typedef enum logic [1:0] {
    ModeOpen   = 2'd0,
    ModeAppend = 2'd1,
    ModeClose  = 2'd2,
    ModeRsvd   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StOpened   = 3'd0,
    StAppended = 3'd1,
    StClosed   = 3'd2,
    StNotFound = 3'd3,
    StTblFull  = 3'd4,
    StStrFull  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    SInit, SIdle, SOpenWr, SFindRd, SFindChk, SAppRd, SAppWr, SDrRd, SDrOut,
    SUnlink1, SUnlink2, SUnlink3, SOut
  } state_e;

  typedef struct packed {
    logic [SlotW-1:0] nxt;
    logic [SlotW-1:0] prv;
    logic [ItemW-1:0] first;
    logic [ItemW-1:0] last;
    logic [15:0]      key;
  } slot_t;
endpackage
`default_nettype wire

// ----- rtl/core/keyed_linked_queue_manager_top.sv -----
// Keyed linked queue manager.
// Input channel s_axis: tdata holds mode [1:0], client_id [17:2], charge_code [33:18].
// Output channel m_axis: tdata holds status [2:0], out_code [18:3], code_valid [19];
// tlast marks the final result item of each input item.
// Open creates a keyed entry at the list tail, append adds a code to the oldest
// entry with the key, close emits the entry's codes in order and then a final
// status item with tlast. Mode three is accepted and dropped without a result.
// Slot records, codes and item links live in synchronous memories with one write
// port and one read port. One item is processed at a time. Append and close search
// the list from the head, reading each slot visited and then comparing its key, and
// report a missing key at the end of the list. After that an open with an existing
// tail rewrites the old tail's link, an append reads and then writes the stores, and
// a close reads and emits each drained code in turn and then unlinks the slot; the
// final result is registered. The table holds 16 entries and the item store 32 codes.
// A stalled receiver holds the output register and the sequencer waits on it; a new
// item is accepted, at the earliest, in the cycle after the last result item is taken.
// After reset the block chains every item of the item store into the free list
// and accepts no item during that pass.
`timescale 1ns / 1ps
`default_nettype none
module keyed_linked_queue_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // mode, client_id, charge_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // status, out_code, code_valid
  output logic             m_axis_tlast
);
  localparam int unsigned SW = klqm_pkg::SlotW;
  localparam int unsigned IW = klqm_pkg::ItemW;
  localparam int unsigned SIW = klqm_pkg::SlotIdxW;
  localparam int unsigned IIW = klqm_pkg::ItemIdxW;

  klqm_pkg::slot_t slot_mem [klqm_pkg::Entries];
  logic [15:0]    val_mem  [klqm_pkg::Items];
  logic [IW-1:0]  link_mem [klqm_pkg::Items];

  logic [klqm_pkg::Entries-1:0] used_q, used_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d;
  logic [IW-1:0] free_q, free_d;
  klqm_pkg::state_e st_q, st_d;
  klqm_pkg::mode_e mode_q, mode_d;
  logic [15:0] key_q, key_d, code_q, code_d;
  logic [SW-1:0] cur_q, cur_d;
  logic [SW:0] cnt_q, cnt_d;
  logic [IW-1:0] it_q, it_d;
  klqm_pkg::slot_t sr_q, srec_q, srec_d;
  logic [15:0] vr_q;
  logic [IW-1:0] lr_q;

  logic ov_q, ov_d, ol_q, ol_d, ocv_q, ocv_d;
  logic [2:0] ost_q, ost_d;
  logic [15:0] oc_q, oc_d;

  logic sw_en; logic [SIW-1:0] sw_a; klqm_pkg::slot_t sw_dat;
  logic [SIW-1:0] sr_a;
  logic vw_en; logic [IIW-1:0] vw_a;
  logic lw_en; logic [IIW-1:0] lw_a; logic [IW-1:0] lw_dat;
  logic [IIW-1:0] ir_a;

  logic [SW-1:0] fslot;
  logic ffound;
  logic out_free;

  always_comb begin
    ffound = 1'b0;
    fslot = klqm_pkg::SlotNull;
    for (int i = int'(klqm_pkg::Entries) - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        ffound = 1'b1;
        fslot = SW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sw_en) slot_mem[sw_a] <= sw_dat;
    sr_q <= slot_mem[sr_a];
    if (vw_en) val_mem[vw_a] <= code_q;
    if (lw_en) link_mem[lw_a] <= lw_dat;
    vr_q <= val_mem[ir_a];
    lr_q <= link_mem[ir_a];
  end

  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (st_q == klqm_pkg::SIdle) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast = ol_q;
  assign m_axis_tdata = {4'd0, ocv_q, oc_q, ost_q};

  always_comb begin
    st_d = st_q; mode_d = mode_q; key_d = key_q; code_d = code_q;
    cur_d = cur_q; cnt_d = cnt_q; it_d = it_q; srec_d = srec_q;
    used_d = used_q; head_d = head_q; tail_d = tail_q; free_d = free_q;
    ov_d = ov_q && !m_axis_tready; ol_d = ol_q; ocv_d = ocv_q;
    ost_d = ost_q; oc_d = oc_q;
    sw_en = 1'b0; sw_a = cur_q[SIW-1:0]; sw_dat = srec_q;
    sr_a = cur_q[SIW-1:0];
    vw_en = 1'b0; vw_a = it_q[IIW-1:0];
    lw_en = 1'b0; lw_a = it_q[IIW-1:0]; lw_dat = klqm_pkg::ItemNull;
    ir_a = it_q[IIW-1:0];
    unique case (st_q)
      klqm_pkg::SInit: begin
        lw_en = 1'b1;
        lw_dat = it_q + IW'(1);
        it_d = it_q + IW'(1);
        if (it_q == IW'(klqm_pkg::Items - 1)) st_d = klqm_pkg::SIdle;
      end
      klqm_pkg::SIdle: begin
        sr_a = tail_q[SIW-1:0];
        if (s_axis_tvalid && s_axis_tready) begin
          mode_d = klqm_pkg::mode_e'(s_axis_tdata[1:0]);
          key_d = s_axis_tdata[17:2];
          code_d = s_axis_tdata[33:18];
          cur_d = head_q;
          cnt_d = '0;
          unique case (klqm_pkg::mode_e'(s_axis_tdata[1:0]))
            klqm_pkg::ModeOpen: begin
              if (!ffound) begin
                ost_d = klqm_pkg::StTblFull;
                st_d = klqm_pkg::SOut;
              end else begin
                sw_en = 1'b1; sw_a = fslot[SIW-1:0];
                sw_dat = '{nxt: klqm_pkg::SlotNull, prv: tail_q,
                           first: klqm_pkg::ItemNull, last: klqm_pkg::ItemNull,
                           key: s_axis_tdata[17:2]};
                used_d[fslot[SIW-1:0]] = 1'b1;
                tail_d = fslot;
                ost_d = klqm_pkg::StOpened;
                if (tail_q == klqm_pkg::SlotNull) begin
                  head_d = fslot;
                  st_d = klqm_pkg::SOut;
                end else begin
                  cur_d = tail_q; it_d = IW'(fslot);
                  st_d = klqm_pkg::SOpenWr;
                end
              end
            end
            klqm_pkg::ModeAppend: st_d = klqm_pkg::SFindRd;
            klqm_pkg::ModeClose: st_d = klqm_pkg::SFindRd;
            klqm_pkg::ModeRsvd: st_d = klqm_pkg::SIdle;
          endcase
        end
      end
      klqm_pkg::SOpenWr: begin
        // The previous tail now points at the new slot.
        sw_en = 1'b1; sw_dat = sr_q; sw_dat.nxt = it_q[SW-1:0];
        st_d = klqm_pkg::SOut;
      end
      klqm_pkg::SFindRd: begin
        if (cur_q == klqm_pkg::SlotNull || cnt_q == (SW+1)'(klqm_pkg::Entries)) begin
          ost_d = klqm_pkg::StNotFound;
          st_d = klqm_pkg::SOut;
        end else st_d = klqm_pkg::SFindChk;
      end
      klqm_pkg::SFindChk: begin
        if (used_q[cur_q[SIW-1:0]] && sr_q.key == key_q) begin
          srec_d = sr_q;
          if (mode_q == klqm_pkg::ModeAppend) begin
            if (free_q == klqm_pkg::ItemNull) begin
              ost_d = klqm_pkg::StStrFull; st_d = klqm_pkg::SOut;
            end else begin
              it_d = free_q; st_d = klqm_pkg::SAppRd;
            end
          end else begin
            it_d = sr_q.first; st_d = klqm_pkg::SDrRd;
          end
        end else begin
          cur_d = sr_q.nxt; cnt_d = cnt_q + (SW+1)'(1);
          st_d = klqm_pkg::SFindRd;
        end
      end
      klqm_pkg::SAppRd: begin
        if (srec_q.last != klqm_pkg::ItemNull) begin
          lw_en = 1'b1; lw_a = srec_q.last[IIW-1:0]; lw_dat = it_q;
        end
        st_d = klqm_pkg::SAppWr;
      end
      klqm_pkg::SAppWr: begin
        free_d = lr_q;
        vw_en = 1'b1;
        lw_en = 1'b1; lw_dat = klqm_pkg::ItemNull;
        sw_en = 1'b1; sw_dat = srec_q; sw_dat.last = it_q;
        if (srec_q.last == klqm_pkg::ItemNull) sw_dat.first = it_q;
        ost_d = klqm_pkg::StAppended;
        st_d = klqm_pkg::SOut;
      end
      klqm_pkg::SDrRd: begin
        if (it_q == klqm_pkg::ItemNull) begin
          if (srec_q.prv == klqm_pkg::SlotNull) head_d = srec_q.nxt;
          if (srec_q.nxt == klqm_pkg::SlotNull) tail_d = srec_q.prv;
          used_d[cur_q[SIW-1:0]] = 1'b0;
          ost_d = klqm_pkg::StClosed;
          st_d = klqm_pkg::SUnlink1;
        end else st_d = klqm_pkg::SDrOut;
      end
      klqm_pkg::SDrOut: begin
        if (out_free) begin
          ov_d = 1'b1; ost_d = klqm_pkg::StClosed; oc_d = vr_q; ocv_d = 1'b1;
          ol_d = 1'b0;
          lw_en = 1'b1; lw_dat = free_q;
          free_d = it_q; it_d = lr_q;
          st_d = klqm_pkg::SDrRd;
        end
      end
      klqm_pkg::SUnlink1: begin
        sr_a = srec_q.prv[SIW-1:0];
        st_d = klqm_pkg::SUnlink2;
      end
      klqm_pkg::SUnlink2: begin
        if (srec_q.prv != klqm_pkg::SlotNull) begin
          sw_en = 1'b1; sw_a = srec_q.prv[SIW-1:0];
          sw_dat = sr_q; sw_dat.nxt = srec_q.nxt;
        end
        sr_a = srec_q.nxt[SIW-1:0];
        st_d = klqm_pkg::SUnlink3;
      end
      klqm_pkg::SUnlink3: begin
        if (srec_q.nxt != klqm_pkg::SlotNull) begin
          sw_en = 1'b1; sw_a = srec_q.nxt[SIW-1:0];
          sw_dat = sr_q; sw_dat.prv = srec_q.prv;
        end
        st_d = klqm_pkg::SOut;
      end
      klqm_pkg::SOut: begin
        if (out_free) begin
          ov_d = 1'b1; oc_d = 16'd0; ocv_d = 1'b0; ol_d = 1'b1;
          st_d = klqm_pkg::SIdle;
        end
      end
      default: st_d = klqm_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= klqm_pkg::SInit;
      used_q <= '0;
      head_q <= klqm_pkg::SlotNull;
      tail_q <= klqm_pkg::SlotNull;
      free_q <= '0;
      it_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      used_q <= used_d;
      head_q <= head_d;
      tail_q <= tail_d;
      free_q <= free_d;
      it_q <= it_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; key_q <= key_d; code_q <= code_d;
    cur_q <= cur_d; cnt_q <= cnt_d; srec_q <= srec_d;
    ol_q <= ol_d; ocv_q <= ocv_d; ost_q <= ost_d; oc_q <= oc_d;
  end
endmodule
`default_nettype wire
